// File: src/gbn_pkg.sv
// Shared types and constants of the go-back-n sender.
// Used by every module under src; depends on nothing.
package gbn_pkg;

  localparam int SEQ_W = 16;
  localparam int TMR_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ALU_W = SEQ_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

  localparam logic [TMR_W-1:0] TIMEOUT_RESET = 16'd100;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ACK = 1'b1;

  typedef struct packed {
    logic             command;
    logic [SEQ_W-1:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] send_seq;
    logic             is_resend;
    logic             finished;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

endpackage

// File: src/go_back_n_sender.sv
// Go-back-n ARQ sender control: top level with config registers and output register.
// Depends on gbn_pkg, gbn_seq and gbn_alu.
//
// Usage:
//   in:  one request per event, command 0 = tick, 1 = acknowledgement with ack_number.
//   out: zero or more results per request; last_of_run marks the final one.
//   cfg: index 0 writes total_frames, index 1 writes timeout_ticks; other indexes
//        are dropped. cfg_ready is always high; write only while the block is idle.
// Sequencing:
//   a tick updates the timer, checks the window and total_frames, advances next
//   when a new frame goes out, checks the timeout and the resend range, then gives
//   the new frame and any resends (up to 1 + WINDOW results). An ack sets base,
//   restarts the timer, checks for the final frame and may give a finished result.
//   All steps share one add/subtract unit, one step per cycle while no result waits
//   on the output register, and in_ready is high only between requests.
// Reset: base and next sequence number return to 1, timer stopped, timeout 100,
//   total_frames 0, output register empty.
// Stalls: results sit in a one-entry output register; while it is full and out_ready
//   is low, a step that gives a result holds. After the final frame is acknowledged
//   every request is dropped until reset.
module go_back_n_sender #(
  parameter int WINDOW = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gbn_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbn_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0]     cfg_data
);

  logic [gbn_pkg::SEQ_W-1:0] total_frames;
  logic [gbn_pkg::TMR_W-1:0] timeout_ticks;
  logic                      slot_free;
  gbn_pkg::emit_t            emit;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  gbn_seq #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_data),
    .total_frames  (total_frames),
    .timeout_ticks (timeout_ticks),
    .slot_free     (slot_free),
    .emit          (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= '0;
      timeout_ticks <= gbn_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gbn_pkg::CFG_TOTAL_FRAMES:  total_frames <= cfg_data;
        gbn_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
          total_frames <= total_frames;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data <= emit.item;
    end
  end

`ifndef SYNTHESIS
  a_fin_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |->
      out_data.last_of_run && !out_data.is_resend && out_data.send_seq == '0)
    else $error("finished result carries a send");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("request taken before run completed");

  a_resend_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_run |=>
      out_valid && out_data.is_resend)
    else $error("run broken before its last result");
`endif

endmodule

// File: src/gbn_alu.sv
// Shared add/subtract unit of the go-back-n sender.
// Depends on gbn_pkg; the borrow of a subtraction is the top result bit.
module gbn_alu (
  input  logic                     op,
  input  logic [gbn_pkg::ALU_W-1:0] a,
  input  logic [gbn_pkg::ALU_W-1:0] b,
  output logic [gbn_pkg::ALU_W:0]   res
);

  always_comb begin
    unique case (op)
      gbn_pkg::OP_SUB: res = {1'b0, a} - {1'b0, b};
      default:         res = {1'b0, a} + {1'b0, b};
    endcase
  end

endmodule

// File: src/gbn_seq.sv
// Sequencer and window state of the go-back-n sender.
// Depends on gbn_pkg and drives one gbn_alu step by step.
module gbn_seq #(
  parameter int WINDOW = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gbn_pkg::in_item_t         in_item,
  input  logic [gbn_pkg::SEQ_W-1:0] total_frames,
  input  logic [gbn_pkg::TMR_W-1:0] timeout_ticks,
  input  logic                      slot_free,
  output gbn_pkg::emit_t            emit
);

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int AW = gbn_pkg::ALU_W;
  localparam int IDX_W = $clog2(WINDOW + 1);
  localparam logic [SW-1:0] SEQ_LIMIT =
    (SEQ_BITS >= SW) ? {SW{1'b1}} : SW'((33'd1 << SEQ_BITS) - 33'd1);

  localparam logic [3:0] IDLE   = 4'd0;
  localparam logic [3:0] T_INC  = 4'd1;
  localparam logic [3:0] T_WIN  = 4'd2;
  localparam logic [3:0] T_CMPW = 4'd3;
  localparam logic [3:0] T_CMPT = 4'd4;
  localparam logic [3:0] T_ADV  = 4'd5;
  localparam logic [3:0] T_TO   = 4'd6;
  localparam logic [3:0] T_RNG  = 4'd7;
  localparam logic [3:0] T_SEND = 4'd8;
  localparam logic [3:0] T_RES  = 4'd9;
  localparam logic [3:0] A_BASE = 4'd10;
  localparam logic [3:0] A_TMR  = 4'd11;
  localparam logic [3:0] A_DONE = 4'd12;
  localparam logic [3:0] A_FIN  = 4'd13;

  logic [3:0]       state;
  logic [SW-1:0]    base;
  logic [SW-1:0]    next;
  logic             running;
  logic [SW-1:0]    elapsed;
  logic             done;
  logic [SW-1:0]    ack;
  logic [AW-1:0]    tmp;
  logic             ok_w;
  logic             send_pend;
  logic [SW-1:0]    send_seq;
  logic             fire;
  logic             run;
  logic [SW-1:0]    cur;
  logic [IDX_W-1:0] idx;

  logic          alu_op;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW:0]   alu_res;
  logic [SW-1:0] limit;
  logic [SW-1:0] ack_m;
  logic          res_last;

  gbn_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_ready = (state == IDLE);
  assign limit = (timeout_ticks == '0) ? SW'(1) : timeout_ticks;
  assign ack_m = ack & SEQ_LIMIT;
  assign res_last = (alu_res[SW-1:0] == next) || (idx == IDX_W'(WINDOW - 1));

  always_comb begin
    alu_op = gbn_pkg::OP_ADD;
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      T_INC: begin
        alu_a = {1'b0, elapsed};
        alu_b = AW'(1);
      end
      T_WIN: begin
        alu_a = {1'b0, base};
        alu_b = AW'(WINDOW);
      end
      T_CMPW: begin
        alu_op = gbn_pkg::OP_SUB;
        alu_a = {1'b0, next};
        alu_b = tmp;
      end
      T_CMPT: begin
        alu_op = gbn_pkg::OP_SUB;
        alu_a = {1'b0, next};
        alu_b = {1'b0, total_frames};
      end
      T_ADV: begin
        alu_a = {1'b0, next};
        alu_b = AW'(1);
      end
      T_TO: begin
        alu_op = gbn_pkg::OP_SUB;
        alu_a = {1'b0, elapsed};
        alu_b = {1'b0, limit};
      end
      T_RNG: begin
        alu_op = gbn_pkg::OP_SUB;
        alu_a = {1'b0, base};
        alu_b = {1'b0, next};
      end
      T_RES: begin
        alu_a = {1'b0, cur};
        alu_b = AW'(1);
      end
      A_BASE: begin
        alu_a = {1'b0, ack_m};
        alu_b = AW'(1);
      end
      A_DONE: begin
        alu_op = gbn_pkg::OP_SUB;
        alu_a = {1'b0, total_frames};
        alu_b = AW'(1);
      end
      default: begin
        alu_op = gbn_pkg::OP_ADD;
      end
    endcase
  end

  always_comb begin
    emit.load = 1'b0;
    emit.item = '0;
    unique case (state)
      T_SEND: begin
        emit.load = slot_free;
        emit.item.send_seq = send_seq;
        emit.item.last_of_run = !run;
      end
      T_RES: begin
        emit.load = slot_free;
        emit.item.send_seq = cur;
        emit.item.is_resend = 1'b1;
        emit.item.last_of_run = res_last;
      end
      A_FIN: begin
        emit.load = slot_free;
        emit.item.finished = 1'b1;
        emit.item.last_of_run = 1'b1;
      end
      default: begin
        emit.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      base <= SW'(1);
      next <= SW'(1);
      running <= 1'b0;
      elapsed <= '0;
      done <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid && !done) begin
            ack <= in_item.ack_number;
            state <= (in_item.command == gbn_pkg::CMD_ACK) ? A_BASE : T_INC;
          end
        end
        T_INC: begin
          send_pend <= 1'b0;
          if (running && elapsed != {SW{1'b1}}) begin
            elapsed <= alu_res[SW-1:0];
          end
          state <= T_WIN;
        end
        T_WIN: begin
          tmp <= alu_res[AW-1:0];
          state <= T_CMPW;
        end
        T_CMPW: begin
          ok_w <= alu_res[AW];
          state <= T_CMPT;
        end
        T_CMPT: begin
          if (ok_w && alu_res[AW] && next < SEQ_LIMIT) begin
            send_pend <= 1'b1;
            send_seq <= next;
            if (base == next) begin
              running <= 1'b1;
              elapsed <= '0;
            end
            state <= T_ADV;
          end else begin
            state <= T_TO;
          end
        end
        T_ADV: begin
          next <= alu_res[SW-1:0];
          state <= T_TO;
        end
        T_TO: begin
          fire <= running && !alu_res[AW];
          if (running && !alu_res[AW]) begin
            elapsed <= '0;
          end
          state <= T_RNG;
        end
        T_RNG: begin
          run <= fire && alu_res[AW];
          cur <= base;
          idx <= '0;
          if (send_pend) begin
            state <= T_SEND;
          end else if (fire && alu_res[AW]) begin
            state <= T_RES;
          end else begin
            state <= IDLE;
          end
        end
        T_SEND: begin
          if (slot_free) begin
            state <= run ? T_RES : IDLE;
          end
        end
        T_RES: begin
          if (slot_free) begin
            cur <= alu_res[SW-1:0];
            idx <= idx + IDX_W'(1);
            if (res_last) begin
              state <= IDLE;
            end
          end
        end
        A_BASE: begin
          base <= (ack_m != SEQ_LIMIT) ? alu_res[SW-1:0] : SEQ_LIMIT;
          state <= A_TMR;
        end
        A_TMR: begin
          running <= (base != next);
          elapsed <= '0;
          state <= A_DONE;
        end
        A_DONE: begin
          if (total_frames != '0 && ack == alu_res[SW-1:0]) begin
            done <= 1'b1;
            state <= A_FIN;
          end else begin
            state <= IDLE;
          end
        end
        A_FIN: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
